// ----- sv/text_console_writer_defines.svh -----
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTH
// property holds at every clock edge outside reset
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition never holds at a clock edge outside reset
`define TCW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, cell constants and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int CELL_COUNT   = COLUMNS * ROWS;
	localparam int SCROLL_CELLS = COLUMNS * (ROWS - 1);
	localparam int ADDR_W       = $clog2(CELL_COUNT);
	localparam int COL_W        = $clog2(COLUMNS + 1);
	localparam int ROW_W        = $clog2(ROWS);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [15:0]       cell_t;

	localparam cell_t      BLANK_CELL   = 16'h0F20;
	localparam logic [7:0] ATTR_BITS    = 8'h0F;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

endpackage

`default_nettype wire

// ----- sv/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- sv/text_console_writer.sv -----
// Sequence: a put passes ST_PUT then ST_DONE, a read ST_RD_ADDR, ST_RD_DATA
//   then ST_DONE, an unused code goes straight to ST_DONE, a clear sweeps every
//   cell, and a newline on the bottom row scrolls the screen up one row first.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: cursor homes at once, then a clearing pass writes blank to every cell,
//   with in_stall high throughout.
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode screen of 16-bit cells with cursor, newline, scroll, clear and
// cell read, driven by a small sequencer around one screen RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_defines.svh"

module text_console_writer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input beat
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  character,
	input  wire logic [10:0] cell_index,
	// result beat
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      read_data,
	output logic [6:0]       cursor_column,
	output logic [4:0]       cursor_row_out
);

	typedef enum logic [3:0] {
		ST_INIT,      // post-reset blanking sweep
		ST_IDLE,      // wait for an input beat
		ST_PUT,       // place a character or handle newline
		ST_CLEAR,     // blanking sweep for clear
		ST_SCR_RD,    // scroll: fetch the cell one row below
		ST_SCR_WR,    // scroll: store it one row up
		ST_SCR_BLANK, // scroll: blank the last row
		ST_RD_ADDR,   // read: address the RAM
		ST_RD_DATA,   // read: capture the RAM data
		ST_DONE       // hand the result to the output register
	} state_t;

	localparam tcw_pkg::addr_t LAST_CELL   = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
	localparam tcw_pkg::addr_t LAST_SCROLL = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS - 1);
	localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
	localparam logic [tcw_pkg::COL_W-1:0] COL_LIMIT = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);

	state_t                    state_q;
	tcw_pkg::addr_t            cnt_q;      // sweep and scroll cell counter
	logic [tcw_pkg::COL_W-1:0] col_q;      // may equal COLUMNS until the next put
	logic [tcw_pkg::ROW_W-1:0] row_q;
	logic [7:0]                char_q;
	tcw_pkg::addr_t            idx_q;
	logic                      in_range_q;
	tcw_pkg::cell_t            data_q;     // result data before the output register
	logic                      out_valid_q;
	tcw_pkg::cell_t            read_data_q;
	logic [6:0]                cursor_column_q;
	logic [4:0]                cursor_row_q;

	// Screen RAM port signals
	logic           ram_we;
	tcw_pkg::addr_t ram_waddr;
	tcw_pkg::cell_t ram_wdata;
	tcw_pkg::addr_t ram_raddr;
	tcw_pkg::cell_t ram_rdata;

	// Put datapath
	logic                      is_newline;
	logic                      wrap;
	logic [tcw_pkg::COL_W-1:0] put_col;
	logic [tcw_pkg::ROW_W-1:0] put_row;
	tcw_pkg::addr_t            put_pos;

	// Input decode
	logic [31:0] idx_ext;
	logic [31:0] col_ext;
	logic [31:0] row_ext;

	assign is_newline = (char_q == tcw_pkg::NEWLINE_CODE);
	// A put that finds the column at the right edge wraps first; the row
	// clamps at the bottom without scrolling.
	assign wrap    = (col_q >= COL_LIMIT);
	assign put_col = wrap ? '0 : col_q;
	assign put_row = (wrap && (row_q != LAST_ROW)) ? row_q + 1'b1 : row_q;
	assign put_pos = tcw_pkg::ADDR_W'(put_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
		+ tcw_pkg::ADDR_W'(put_col);

	assign idx_ext = 32'(cell_index);
	// Cursor outputs are masked to the field widths.
	assign col_ext = 32'(col_q);
	assign row_ext = 32'(row_q);

	// RAM port steering: one write and one read per cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = tcw_pkg::BLANK_CELL;
		ram_raddr = idx_q;
		unique case (state_q)
			ST_INIT, ST_CLEAR, ST_SCR_BLANK: begin
				ram_we = 1'b1;
			end
			ST_PUT: begin
				if (!is_newline) begin
					ram_we    = 1'b1;
					ram_waddr = put_pos;
					ram_wdata = {tcw_pkg::ATTR_BITS, char_q};
				end
			end
			ST_SCR_RD: begin
				ram_raddr = cnt_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
			end
			ST_SCR_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(tcw_pkg::CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer, cursor and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_INIT;
			cnt_q           <= '0;
			col_q           <= '0;
			row_q           <= '0;
			char_q          <= '0;
			idx_q           <= '0;
			in_range_q      <= 1'b0;
			data_q          <= '0;
			out_valid_q     <= 1'b0;
			read_data_q     <= '0;
			cursor_column_q <= '0;
			cursor_row_q    <= '0;
		end else begin
			// Drop the result once the downstream side takes it; in ST_DONE the
			// output register is reloaded below instead.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						char_q     <= character;
						idx_q      <= idx_ext[tcw_pkg::ADDR_W-1:0];
						in_range_q <= (idx_ext < 32'(tcw_pkg::CELL_COUNT));
						data_q     <= '0;
						cnt_q      <= '0;
						unique case (operation)
							tcw_pkg::OP_PUT:   state_q <= ST_PUT;
							tcw_pkg::OP_CLEAR: state_q <= ST_CLEAR;
							tcw_pkg::OP_READ:  state_q <= ST_RD_ADDR;
							default:           state_q <= ST_DONE;
						endcase
					end
				end
				ST_PUT: begin
					if (is_newline) begin
						col_q <= '0;
						if (row_q == LAST_ROW) begin
							state_q <= ST_SCR_RD;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_DONE;
						end
					end else begin
						col_q   <= put_col + 1'b1;
						row_q   <= put_row;
						state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						col_q   <= '0;
						row_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q == LAST_SCROLL) ? ST_SCR_BLANK : ST_SCR_RD;
				end
				ST_SCR_BLANK: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					data_q  <= in_range_q ? ram_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the output register is free.
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						read_data_q     <= data_q;
						cursor_column_q <= col_ext[6:0];
						cursor_row_q    <= row_ext[4:0];
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign cursor_column  = cursor_column_q;
	assign cursor_row_out = cursor_row_q;

	`TCW_NEVER(a_col_bound, col_q > COL_LIMIT, "cursor column past the right edge")
	`TCW_NEVER(a_row_bound, row_q > LAST_ROW, "cursor row past the bottom row")
	`TCW_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "idle after accept")
	`TCW_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state_q == ST_DONE),
		"result without a finished item")
	`TCW_NEVER(a_scroll_range, (state_q == ST_SCR_RD) && (cnt_q > LAST_SCROLL),
		"scroll copy beyond the last source row")

endmodule

`default_nettype wire
